// ----- hw/rtl/mibr_pkg.sv -----
// Shared types and constants for the mesh index batch remapper.
package mibr_pkg;

    // Field widths
    localparam int unsigned VERT_W  = 16;
    localparam int unsigned LOCAL_W = 20;
    localparam int unsigned BATCH_W = 12;
    localparam int unsigned BSZ_W   = 21;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned CFG_W   = 32;

    // Part tag stored with each table entry; zero means cleared
    localparam int unsigned EPOCH_W = 12;

    localparam logic [BSZ_W-1:0]   BATCH_LIMIT   = 21'd1048576;
    localparam logic [BSZ_W-1:0]   BSZ_RESET     = 21'd500000;
    localparam logic [BATCH_W-1:0] BATCH_NUM_MAX = 12'd4095;

    // Register indexes
    localparam logic CFG_BATCH_SIZE  = 1'b0;
    localparam logic CFG_INDEX_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic accept;    // take the input item and start the table read
        logic fire;      // complete the item into the output register
        logic clr_step;  // clear one table entry
    } t_cmd;

    typedef struct packed {
        logic out_free;  // output register can take an item this cycle
        logic wrap;      // the item being completed exhausts the part tags
        logic clr_done;  // clearing pass is at its last entry
    } t_status;

endpackage

// ----- hw/rtl/mibr_ctrl.sv -----
// Control state machine for the mesh index batch remapper.
module mibr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mibr_pkg::t_status i_st,
    output logic              o_in_stall,
    output mibr_pkg::t_cmd    o_cmd
);
    import mibr_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register; reset starts with a clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.fire = i_st.out_free;
                if (i_st.out_free) begin
                    n_state = i_st.wrap ? ST_CLEAR : ST_IDLE;
                end
            end
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_st.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // An accepted item is executed next
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == ST_EXEC)
        else $error("accepted item not followed by execute");

    // Tag exhaustion forces a clearing pass
    a_wrap_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && i_st.out_free && i_st.wrap) |=> r_state == ST_CLEAR)
        else $error("tag wrap without clearing pass");

    // Clearing pass ends at its last entry
    a_clear_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && i_st.clr_done) |=> r_state == ST_IDLE)
        else $error("clearing pass overran");

endmodule

// ----- hw/rtl/mibr_datapath.sv -----
// Datapath: configuration, remap table, part counters and output register.
module mibr_datapath #(
    parameter int unsigned MAX_VERTICES = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mibr_pkg::t_cmd                i_cmd,
    output mibr_pkg::t_status             o_st,
    // configuration
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_index,
    input  logic [mibr_pkg::CFG_W-1:0]    i_cfg_data,
    // input item
    input  logic [mibr_pkg::VERT_W-1:0]   i_orig_index,
    input  logic                          i_last_of_mesh,
    // output item
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [mibr_pkg::LOCAL_W-1:0]  o_mapped_index,
    output logic                          o_is_new_vertex,
    output logic [mibr_pkg::VERT_W-1:0]   o_source_vertex,
    output logic [mibr_pkg::BATCH_W-1:0]  o_batch_number,
    output logic                          o_last_in_batch
);
    import mibr_pkg::*;

    localparam int unsigned AW      = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned ENTRY_W = EPOCH_W + LOCAL_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    logic [ENTRY_W-1:0] r_mem [MAX_VERTICES];

    logic [BSZ_W-1:0]   r_batch_size;
    logic [CNT_W-1:0]   r_index_count;
    logic [VERT_W-1:0]  r_v;
    logic               r_last;
    logic [ENTRY_W-1:0] r_rd_data;
    logic [LOCAL_W-1:0] r_pos;
    logic [LOCAL_W-1:0] r_next;
    logic [BATCH_W-1:0] r_batch;
    logic [EPOCH_W-1:0] r_epoch;
    logic [AW-1:0]      r_clr_addr;

    logic               r_out_valid;
    logic [LOCAL_W-1:0] r_out_mapped;
    logic               r_out_new;
    logic [VERT_W-1:0]  r_out_src;
    logic [BATCH_W-1:0] r_out_batch;
    logic               r_out_last;

    logic [BSZ_W-1:0]   bs;
    logic               passthru;
    logic               in_table;
    logic               hit;
    logic [LOCAL_W-1:0] mapped;
    logic               closes;
    logic               part_end;
    logic [AW-1:0]      v_addr;
    logic [AW-1:0]      in_addr;
    logic [EPOCH_W-1:0] n_epoch;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_size  <= BSZ_RESET;
            r_index_count <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BATCH_SIZE:  r_batch_size  <= i_cfg_data[BSZ_W-1:0];
                CFG_INDEX_COUNT: r_index_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the part size into its meaningful range
    always_comb begin
        if (r_batch_size == '0) begin
            bs = BSZ_W'(1);
        end else if (r_batch_size > BATCH_LIMIT) begin
            bs = BATCH_LIMIT;
        end else begin
            bs = r_batch_size;
        end
    end

    assign in_addr  = AW'(i_orig_index);
    assign v_addr   = AW'(r_v);
    assign in_table = (32'(r_v) < 32'(MAX_VERTICES));
    assign passthru = (r_index_count < CNT_W'(bs));
    assign hit      = in_table && (r_rd_data[ENTRY_W-1:LOCAL_W] == r_epoch);
    assign mapped   = hit ? r_rd_data[LOCAL_W-1:0] : r_next;
    assign closes   = r_last || (({1'b0, r_pos} + BSZ_W'(1)) >= bs);
    assign part_end = i_cmd.fire && (passthru ? r_last : closes);
    assign n_epoch  = (r_epoch == EPOCH_MAX) ? EPOCH_W'(1) : r_epoch + EPOCH_W'(1);

    assign o_st.out_free = !r_out_valid || !i_out_stall;
    assign o_st.wrap     = part_end && (r_epoch == EPOCH_MAX);
    assign o_st.clr_done = (r_clr_addr == LAST_ADDR);

    // Capture the item on acceptance
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_v    <= i_orig_index;
            r_last <= i_last_of_mesh;
        end
    end

    // Remap table: read on acceptance, write on first use or while clearing
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_data <= r_mem[in_addr];
        end
        if (i_cmd.clr_step) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.fire && !passthru && in_table && !hit) begin
            r_mem[v_addr] <= {r_epoch, r_next};
        end
    end

    // Clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= o_st.clr_done ? '0 : r_clr_addr + AW'(1);
        end
    end

    // Part position, local numbering, part number and tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_next  <= '0;
            r_batch <= '0;
            r_epoch <= EPOCH_W'(1);
        end else if (i_cmd.fire) begin
            if (part_end) begin
                r_pos   <= '0;
                r_next  <= '0;
                r_epoch <= n_epoch;
                if (r_last) begin
                    r_batch <= '0;
                end else if (r_batch != BATCH_NUM_MAX) begin
                    r_batch <= r_batch + BATCH_W'(1);
                end
            end else if (!passthru) begin
                r_pos <= r_pos + LOCAL_W'(1);
                if (!hit) begin
                    r_next <= r_next + LOCAL_W'(1);
                end
            end
        end
    end

    // Output register; hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fire) begin
            r_out_src <= r_v;
            if (passthru) begin
                r_out_mapped <= LOCAL_W'(r_v);
                r_out_new    <= 1'b0;
                r_out_batch  <= '0;
                r_out_last   <= r_last;
            end else begin
                r_out_mapped <= mapped;
                r_out_new    <= !hit;
                r_out_batch  <= r_batch;
                r_out_last   <= closes;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_mapped_index  = r_out_mapped;
    assign o_is_new_vertex = r_out_new;
    assign o_source_vertex = r_out_src;
    assign o_batch_number  = r_out_batch;
    assign o_last_in_batch = r_out_last;

    // Tag zero is reserved for cleared entries
    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("part tag reached the cleared value");

    // A part end restarts the numbering
    a_part_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        part_end |=> (r_pos == '0 && r_next == '0))
        else $error("position not restarted after part end");

    // Within a part the position advances by one per item
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fire && !passthru && !closes) |=> r_pos == $past(r_pos) + LOCAL_W'(1))
        else $error("position did not advance");

endmodule

// ----- hw/rtl/mesh_index_batch_remapper.sv -----
// Top level of the mesh index batch remapper.
//
// Input channel (i_in_valid / o_in_stall) carries one vertex index per item
// with its end-of-mesh mark. Output channel (o_out_valid / i_out_stall)
// returns one item per input: local index, first-use flag, source vertex,
// part number and part-closing mark. The configuration channel writes the
// part size (index 0) and the mesh index count (index 1); write it only
// while no item is in flight.
// Each item passes through idle, where it is accepted and the remap table
// is read, then execute, where the lookup is resolved, the table written and
// the output register loaded. An item is taken only in idle, so no new item
// is accepted while the last one is in execute, which waits for a free output
// register. While the receiver stalls the output register holds its item,
// and a further item may be accepted and waits in execute until the register
// frees.
// Table entries carry a part tag instead of per-entry valid marks. After
// reset, and after every 4095 parts, a clearing pass over all MAX_VERTICES
// entries runs during which no item is accepted (configuration is still taken).
// Reset clears the counters and the output valid.
module mesh_index_batch_remapper #(
    parameter int unsigned MAX_VERTICES = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [mibr_pkg::CFG_W-1:0]    i_cfg_data,
    // input item
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [mibr_pkg::VERT_W-1:0]   i_orig_index,
    input  logic                          i_last_of_mesh,
    // output item
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mibr_pkg::LOCAL_W-1:0]  o_mapped_index,
    output logic                          o_is_new_vertex,
    output logic [mibr_pkg::VERT_W-1:0]   o_source_vertex,
    output logic [mibr_pkg::BATCH_W-1:0]  o_batch_number,
    output logic                          o_last_in_batch
);
    import mibr_pkg::*;

    t_cmd    cmd;
    t_status st;

    // Registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    mibr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (st),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    mibr_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_st            (st),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_orig_index    (i_orig_index),
        .i_last_of_mesh  (i_last_of_mesh),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_mapped_index  (o_mapped_index),
        .o_is_new_vertex (o_is_new_vertex),
        .o_source_vertex (o_source_vertex),
        .o_batch_number  (o_batch_number),
        .o_last_in_batch (o_last_in_batch)
    );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the mesh index batch remapper.
module tb_top;
    import mibr_pkg::*;

    localparam int unsigned TABLE_DEPTH    = 65536;
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned WATCHDOG_LIMIT = 250000;
    localparam int unsigned MAX_REPORTS    = 30;
    localparam int unsigned RANDOM_ITEMS   = 440;
    localparam int unsigned SAT_ITEMS      = 40;

    // One output item as the block presents it
    typedef struct packed {
        logic [LOCAL_W-1:0] mapped;
        logic               is_new;
        logic [VERT_W-1:0]  source;
        logic [BATCH_W-1:0] batch;
        logic               closes;
    } t_remap_res;

    typedef struct {
        logic       known;
        t_remap_res res;
    } t_typed_res;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_SET_BSZ,
        ROW_SET_CNT
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [31:0] data;
        logic        mesh_end;
        logic        known;
        t_remap_res  res;
    } t_stim_row;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_cfg_valid    = 1'b0;
    logic                i_cfg_index    = CFG_BATCH_SIZE;
    logic [CFG_W-1:0]    i_cfg_data     = '0;
    logic                i_in_valid     = 1'b0;
    logic [VERT_W-1:0]   i_orig_index   = '0;
    logic                i_last_of_mesh = 1'b0;
    logic                i_out_stall    = 1'b0;
    logic                o_cfg_ready;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [LOCAL_W-1:0]  o_mapped_index;
    logic                o_is_new_vertex;
    logic [VERT_W-1:0]   o_source_vertex;
    logic [BATCH_W-1:0]  o_batch_number;
    logic                o_last_in_batch;

    // Remapper state as predicted; a table entry is live when its epoch matches
    logic [LOCAL_W-1:0]  remap_local [TABLE_DEPTH];
    int unsigned         remap_epoch [TABLE_DEPTH];
    int unsigned         part_epoch  = 1;
    logic [LOCAL_W-1:0]  part_pos    = '0;
    logic [LOCAL_W-1:0]  next_local  = '0;
    logic [BATCH_W-1:0]  part_num    = '0;
    logic [BSZ_W-1:0]    bsz_reg     = BSZ_RESET;
    logic [CNT_W-1:0]    cnt_reg     = '0;

    t_remap_res  expected_q [$];
    t_typed_res  typed_q [$];
    t_stim_row   stim_rows [$];

    int unsigned items_in        = 0;
    int unsigned results_checked = 0;
    int unsigned cfg_writes      = 0;
    int unsigned passthru_items  = 0;
    int unsigned first_uses      = 0;
    int unsigned parts_closed    = 0;
    int unsigned saturated_hits  = 0;
    int unsigned fail_count      = 0;
    int unsigned quiet_cycles    = 0;
    int unsigned stall_left      = 0;
    int unsigned rx_calm_left    = 0;
    int unsigned tx_calm_left    = 0;

    mesh_index_batch_remapper uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_orig_index    (i_orig_index),
        .i_last_of_mesh  (i_last_of_mesh),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_mapped_index  (o_mapped_index),
        .o_is_new_vertex (o_is_new_vertex),
        .o_source_vertex (o_source_vertex),
        .o_batch_number  (o_batch_number),
        .o_last_in_batch (o_last_in_batch)
    );

    always #5 i_clk = ~i_clk;

    // Part size after clamping zero and oversize values
    function automatic int unsigned eff_size(input logic [BSZ_W-1:0] bs);
        if (bs == '0) return 1;
        if (bs > BATCH_LIMIT) return 32'(BATCH_LIMIT);
        return 32'(bs);
    endfunction

    // Drop every live table entry and restart the local numbering
    function void open_part();
        part_epoch = part_epoch + 1;
        part_pos   = '0;
        next_local = '0;
    endfunction

    // Work out the output item for one vertex index and advance the state
    function automatic t_remap_res remap_predict(input logic [VERT_W-1:0] v,
                                                 input logic mesh_end);
        t_remap_res  res;
        int unsigned lim;
        lim        = eff_size(bsz_reg);
        res.source = v;
        if (cnt_reg < lim) begin
            res.mapped = LOCAL_W'(v);
            res.is_new = 1'b0;
            res.batch  = '0;
            res.closes = mesh_end;
            passthru_items++;
            if (mesh_end) begin
                open_part();
                part_num = '0;
            end
            return res;
        end
        if (remap_epoch[v] == part_epoch) begin
            res.mapped = remap_local[v];
            res.is_new = 1'b0;
        end else begin
            res.mapped     = next_local;
            res.is_new     = 1'b1;
            remap_local[v] = next_local;
            remap_epoch[v] = part_epoch;
            next_local     = next_local + 1'b1;
            first_uses++;
        end
        res.batch  = part_num;
        res.closes = mesh_end || (int'(part_pos) + 1 >= lim);
        if (part_num == BATCH_NUM_MAX) saturated_hits++;
        if (res.closes) begin
            parts_closed++;
            open_part();
            if (mesh_end) part_num = '0;
            else if (part_num != BATCH_NUM_MAX) part_num = part_num + 1'b1;
        end else begin
            part_pos = part_pos + 1'b1;
        end
        return res;
    endfunction

    function void check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    // Mirror register writes, predict accepted items, check returned items
    always @(posedge i_clk) begin : scoreboard
        t_remap_res pred;
        t_remap_res got;
        t_typed_res typed;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_writes++;
                if (i_cfg_index == CFG_BATCH_SIZE) bsz_reg = i_cfg_data[BSZ_W-1:0];
                else cnt_reg = i_cfg_data[CNT_W-1:0];
            end
            if (i_in_valid && !o_in_stall) begin
                items_in++;
                pred = remap_predict(i_orig_index, i_last_of_mesh);
                if (typed_q.size() != 0) begin
                    typed = typed_q.pop_front();
                    if (typed.known) pred = typed.res;
                end
                expected_q = {expected_q, pred};
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    $error("output item with no expectation pending");
                end else begin
                    pred = expected_q.pop_front();
                    got  = {o_mapped_index, o_is_new_vertex, o_source_vertex,
                            o_batch_number, o_last_in_batch};
                    results_checked++;
                    check_field("mapped_index", 32'(pred.mapped), 32'(got.mapped));
                    check_field("is_new_vertex", 32'(pred.is_new), 32'(got.is_new));
                    check_field("source_vertex", 32'(pred.source), 32'(got.source));
                    check_field("batch_number", 32'(pred.batch), 32'(got.batch));
                    check_field("last_in_batch", 32'(pred.closes), 32'(got.closes));
                end
            end
        end
    end

    // Receiver stalls: mostly short, a few long, with calm stretches
    always @(posedge i_clk) begin : rx_stall
        int unsigned r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (rx_calm_left != 0) begin
            rx_calm_left <= rx_calm_left - 1;
            i_out_stall  <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                i_out_stall <= 1'b0;
            end else if (r < 88) begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(0, 2);
            end else if (r < 97) begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(3, 11);
            end else if (r < 99) begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(29, 79);
            end else begin
                i_out_stall  <= 1'b0;
                rx_calm_left <= 100;
            end
        end
    end

    // End the run when no handshake of any kind happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $error("no handshake for %0d cycles, %0d results outstanding",
                       quiet_cycles, expected_q.size());
                $display("FAIL mesh_index_batch_remapper");
                $finish;
            end
        end
    end

    // Sender gap before the next item
    function automatic int unsigned send_gap();
        int unsigned r;
        if (tx_calm_left != 0) begin
            tx_calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            tx_calm_left = 30;
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input logic [VERT_W-1:0] v, input logic mesh_end);
        int unsigned gap;
        gap = send_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_orig_index   <= v;
        i_last_of_mesh <= mesh_end;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Hold the sender until every expected item has come back; the extra edge
    // lets the scoreboard log the item accepted at the previous edge
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register; keep valid high when another write follows
    task automatic cfg_write(input logic idx, input logic [31:0] data, input logic more);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (!more) i_cfg_valid <= 1'b0;
    endtask

    function void row_cfg(input t_row_kind kind, input logic [31:0] data);
        t_stim_row row;
        row.kind     = kind;
        row.data     = data;
        row.mesh_end = 1'b0;
        row.known    = 1'b0;
        row.res      = '0;
        stim_rows    = {stim_rows, row};
    endfunction

    function void row_item(input logic [VERT_W-1:0] v, input logic mesh_end,
                           input logic known, input logic [LOCAL_W-1:0] mapped,
                           input logic is_new, input logic [BATCH_W-1:0] batch,
                           input logic closes);
        t_stim_row row;
        row.kind     = ROW_ITEM;
        row.data     = 32'(v);
        row.mesh_end = mesh_end;
        row.known    = known;
        row.res      = {mapped, is_new, v, batch, closes};
        stim_rows    = {stim_rows, row};
    endfunction

    function automatic logic [31:0] pick_bsz();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return 32'd0;
        if (r < 15) return 32'd1;
        if (r < 75) return $urandom_range(2, 12);
        if (r < 85) return $urandom_range(13, 64);
        if (r < 88) return 32'h0010_0000;
        if (r < 90) return 32'h001F_FFFF;
        if (r < 92) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_cnt(input logic [31:0] bs);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 32'hFFFF_FFFF;
        if (r < 70) return $urandom;
        if (r < 80) return 32'd0;
        return eff_size(bs[BSZ_W-1:0]) - $urandom_range(0, 1);
    endfunction

    initial begin : stimulus
        t_stim_row   row;
        t_typed_res  typed;
        logic        more;
        logic        mesh_end;
        logic [31:0] bs;
        logic [15:0] base;
        logic [15:0] v;
        int unsigned spread;
        int unsigned len;
        int unsigned r;
        int unsigned sent;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: large part size, zero count, so indices pass through
        row_item(16'h0000, 1'b0, 1'b1, 20'h00000, 1'b0, 12'd0, 1'b0);
        row_item(16'hFFFF, 1'b0, 1'b1, 20'h0FFFF, 1'b0, 12'd0, 1'b0);
        row_item(16'h1234, 1'b1, 1'b1, 20'h01234, 1'b0, 12'd0, 1'b1);
        // Parts of four: first use, repeat, closing on a full part
        row_cfg(ROW_SET_BSZ, 32'd4);
        row_cfg(ROW_SET_CNT, 32'hFFFF_FFFF);
        row_item(16'h0007, 1'b0, 1'b1, 20'd0, 1'b1, 12'd0, 1'b0);
        row_item(16'h0009, 1'b0, 1'b1, 20'd1, 1'b1, 12'd0, 1'b0);
        row_item(16'h0007, 1'b0, 1'b1, 20'd0, 1'b0, 12'd0, 1'b0);
        row_item(16'hFFFF, 1'b0, 1'b1, 20'd2, 1'b1, 12'd0, 1'b1);
        row_item(16'h0007, 1'b0, 1'b1, 20'd0, 1'b1, 12'd1, 1'b0);
        row_item(16'h0007, 1'b1, 1'b1, 20'd0, 1'b0, 12'd1, 1'b1);
        // Zero part size acts as one
        row_cfg(ROW_SET_BSZ, 32'd0);
        row_item(16'h0005, 1'b0, 1'b1, 20'd0, 1'b1, 12'd0, 1'b1);
        row_item(16'h0005, 1'b0, 1'b1, 20'd0, 1'b1, 12'd1, 1'b1);
        // Oversize part size clamps to the limit; upper data bits ignored
        row_cfg(ROW_SET_BSZ, 32'hFFFF_FFFF);
        row_item(16'h0003, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0);
        row_item(16'h0003, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0);
        // Shrink the part mid-mesh: position already past the new size
        row_cfg(ROW_SET_BSZ, 32'd2);
        row_item(16'h0003, 1'b0, 1'b1, 20'd0, 1'b0, 12'd2, 1'b1);
        // Count just below the limit: pass-through, end of mesh resets part number
        row_cfg(ROW_SET_BSZ, 32'h0010_0000);
        row_cfg(ROW_SET_CNT, 32'h000F_FFFF);
        row_item(16'hABCD, 1'b0, 1'b1, 20'h0ABCD, 1'b0, 12'd0, 1'b0);
        row_item(16'h0001, 1'b1, 1'b1, 20'h00001, 1'b0, 12'd0, 1'b1);
        // Count equal to the size: remapped
        row_cfg(ROW_SET_CNT, 32'h0010_0000);
        row_item(16'h8000, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0);
        row_item(16'h8000, 1'b1, 1'b1, 20'd0, 1'b0, 12'd0, 1'b1);
        // Size one from a word with high garbage, zero count
        row_cfg(ROW_SET_BSZ, 32'hFFE0_0001);
        row_cfg(ROW_SET_CNT, 32'd0);
        row_item(16'h0002, 1'b0, 1'b1, 20'h00002, 1'b0, 12'd0, 1'b0);
        row_cfg(ROW_SET_CNT, 32'd1);
        row_item(16'hFFFF, 1'b1, 1'b1, 20'd0, 1'b1, 12'd0, 1'b1);

        for (int i = 0; i < stim_rows.size(); i++) begin
            row = stim_rows[i];
            if (row.kind == ROW_ITEM) begin
                typed.known = row.known;
                typed.res   = row.res;
                typed_q     = {typed_q, typed};
                send_item(row.data[VERT_W-1:0], row.mesh_end);
            end else begin
                if (i == 0 || stim_rows[i-1].kind == ROW_ITEM) settle();
                more = (i + 1 < stim_rows.size()) && (stim_rows[i+1].kind != ROW_ITEM);
                cfg_write((row.kind == ROW_SET_BSZ) ? CFG_BATCH_SIZE : CFG_INDEX_COUNT,
                          row.data, more);
            end
        end

        // A run of one-index parts, each advancing the part number
        settle();
        cfg_write(CFG_BATCH_SIZE, 32'd1, 1'b1);
        cfg_write(CFG_INDEX_COUNT, 32'hFFFF_FFFF, 1'b0);
        for (int i = 0; i < SAT_ITEMS; i++) send_item(16'($urandom), 1'b0);
        send_item(16'($urandom), 1'b1);

        // Random meshes: small vertex pools so repeats are common
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            bs = pick_bsz();
            cfg_write(CFG_BATCH_SIZE, bs, 1'b1);
            cfg_write(CFG_INDEX_COUNT, pick_cnt(bs), 1'b0);
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 80)
                                                 : $urandom_range(1, 40);
            base   = 16'($urandom);
            spread = $urandom_range(1, 12);
            v      = base;
            for (int k = 0; k < len; k++) begin
                if (k == len / 2 && $urandom_range(0, 99) < 15) begin
                    settle();
                    cfg_write(CFG_BATCH_SIZE, pick_bsz(), 1'b0);
                end
                r = $urandom_range(0, 99);
                if (r < 70) v = base + 16'($urandom_range(0, spread));
                else if (r < 80) v = 16'($urandom);
                else if (r < 85) v = 16'h0000;
                else if (r < 90) v = 16'hFFFF;
                mesh_end = (k == len - 1) || ($urandom_range(0, 99) < 3);
                send_item(v, mesh_end);
                sent++;
            end
        end

        settle();
        $display("Checked %0d of %0d items after %0d register writes: %0d passed through,",
                 results_checked, items_in, cfg_writes, passthru_items);
        $display("%0d first uses, %0d parts closed, %0d items at the saturated part number.",
                 first_uses, parts_closed, saturated_hits);
        if (fail_count == 0) begin
            $display("PASS mesh_index_batch_remapper");
        end else begin
            $display("FAIL mesh_index_batch_remapper");
        end
        $finish;
    end

endmodule
